// ----- rtl/fptx_pkg.sv -----
// fptx_pkg: shared types, constants and helpers of the fast-packet transmit framer
// no dependencies; used by fptx_front, fptx_queue, fptx_back and fast_packet_tx_framer_top

package fptx_pkg;

    localparam logic [17:0] CLAIM_GROUP  = 18'd60928;
    localparam logic [7:0]  MAX_BYTES    = 8'd223;
    localparam logic [7:0]  SINGLE_LIMIT = 8'd8;
    localparam logic [7:0]  CFA_RESET    = 8'd254;

    localparam int TBL_ENTRIES = 64;
    localparam int TBL_IDX_W   = $clog2(TBL_ENTRIES);
    localparam int TBL_CNT_W   = TBL_IDX_W + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    localparam int          APB_ADDR_W = 3;
    localparam logic [2:0]  ADDR_CFA   = 3'd0;

    typedef struct packed {
        logic [28:0] can_identifier;
        logic [17:0] group_number;
        logic [7:0]  source_address;
        logic        claim_busy;
        logic        fast_mode;
        logic [7:0]  message_length;
        logic [7:0]  payload_byte;
        logic        byte_last;
    } in_word_t;

    typedef struct packed {
        logic [28:0] frame_identifier;
        logic [63:0] frame_data;
        logic        frame_last;
    } out_word_t;

    // one byte that goes into a frame, with message context on the first byte
    typedef struct packed {
        logic        start;
        logic        fast;
        logic [28:0] ident;
        logic [2:0]  seq;
        logic [7:0]  length;
        logic [7:0]  data;
        logic        done;
    } qent_t;

    typedef struct packed {
        logic  push;
        qent_t entry;
    } qpush_t;

    typedef struct packed {
        logic  valid;
        qent_t entry;
    } qhead_t;

    function automatic logic [63:0] put_byte(input logic [63:0] word,
                                            input logic [2:0]  slot,
                                            input logic [7:0]  value);
        logic [63:0] res;
        res = word;
        res[{slot, 3'b000} +: 8] = value;
        return res;
    endfunction

endpackage

// ----- rtl/fptx_front.sv -----
// fptx_front: accepts payload words, applies drop and length rules, looks up sequence numbers
// depends on fptx_pkg; feeds fptx_queue

module fptx_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fptx_pkg::in_word_t in_data,
    input  logic [7:0]        claim_fail_address,
    input  logic              q_full,
    output fptx_pkg::qpush_t  q_wr
);

    typedef enum logic [3:0] {
        S_ACCEPT = 4'b0001,
        S_READ   = 4'b0010,
        S_CMP    = 4'b0100,
        S_PUSH   = 4'b1000
    } state_t;

    typedef struct packed {
        logic [17:0] group;
        logic [2:0]  seq;
    } tbl_entry_t;

    state_t                          state_reg, state_next;
    logic [7:0]                      pos_reg, pos_next;
    logic                            dropped_reg, dropped_next;
    logic                            fast_reg, fast_next;
    logic                            noaddr_reg, noaddr_next;
    logic [fptx_pkg::TBL_CNT_W-1:0]  fill_reg, fill_next;
    logic [2:0]                      zseq_reg, zseq_next;
    logic [fptx_pkg::TBL_IDX_W-1:0]  scan_reg, scan_next;
    logic [17:0]                     grp_reg, grp_next;
    fptx_pkg::qent_t                 pend_reg, pend_next;
    tbl_entry_t                      rd_reg;

    tbl_entry_t                      tbl_mem [fptx_pkg::TBL_ENTRIES];
    logic                            tbl_we;
    logic [fptx_pkg::TBL_IDX_W-1:0]  tbl_waddr;
    tbl_entry_t                      tbl_wdata;

    logic                            accept;
    logic                            first;
    logic                            drop_new;
    logic                            eff_drop;
    logic                            eff_fast;
    logic [7:0]                      limit;
    logic [8:0]                      pos_inc;
    logic                            wr_byte;
    logic                            done;
    logic                            has_room;
    fptx_pkg::qent_t                 entry;
    logic [fptx_pkg::TBL_CNT_W-1:0]  scan_inc;

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        dropped_next = dropped_reg;
        fast_next    = fast_reg;
        noaddr_next  = noaddr_reg;
        fill_next    = fill_reg;
        zseq_next    = zseq_reg;
        scan_next    = scan_reg;
        grp_next     = grp_reg;
        pend_next    = pend_reg;
        tbl_we       = 1'b0;
        tbl_waddr    = fill_reg[fptx_pkg::TBL_IDX_W-1:0];
        tbl_wdata    = '{group: grp_reg, seq: 3'd0};
        q_wr.push    = 1'b0;

        in_ready = (state_reg == S_ACCEPT) && !q_full;
        accept   = in_valid && in_ready;
        first    = (pos_reg == 8'd0);
        drop_new = (in_data.claim_busy && (in_data.group_number != fptx_pkg::CLAIM_GROUP))
                   || noaddr_reg;
        eff_drop = first ? drop_new : dropped_reg;
        eff_fast = first ? in_data.fast_mode : fast_reg;
        limit    = eff_fast ? fptx_pkg::MAX_BYTES : fptx_pkg::SINGLE_LIMIT;
        pos_inc  = {1'b0, pos_reg} + 9'd1;
        wr_byte  = !eff_drop && (pos_reg < limit);
        done     = in_data.byte_last || (pos_inc >= {1'b0, limit});
        has_room = (fill_reg < fptx_pkg::TBL_CNT_W'(fptx_pkg::TBL_ENTRIES));
        scan_inc = {1'b0, scan_reg} + fptx_pkg::TBL_CNT_W'(1);

        entry.start  = first;
        entry.fast   = eff_fast;
        entry.ident  = in_data.can_identifier;
        entry.seq    = 3'd0;
        entry.length = in_data.message_length;
        entry.data   = in_data.payload_byte;
        entry.done   = done;

        unique case (state_reg)
            S_ACCEPT:
            begin
                if (accept)
                begin
                    if (first)
                    begin
                        dropped_next = drop_new;
                        fast_next    = in_data.fast_mode;
                        if (!drop_new && (in_data.source_address == claim_fail_address))
                            noaddr_next = 1'b1;
                    end
                    if (!wr_byte)
                    begin
                        if (in_data.byte_last)
                        begin
                            pos_next     = 8'd0;
                            dropped_next = 1'b0;
                        end
                        else if (eff_drop && first)
                        begin
                            pos_next = 8'd1;
                        end
                    end
                    else
                    begin
                        pos_next  = (done && in_data.byte_last) ? 8'd0 : pos_inc[7:0];
                        q_wr.push = 1'b1;
                        if (first && in_data.fast_mode)
                        begin
                            if (in_data.group_number == 18'd0)
                            begin
                                if (has_room)
                                begin
                                    zseq_next = zseq_reg + 3'd1;
                                    entry.seq = zseq_reg + 3'd1;
                                end
                            end
                            else if (fill_reg == '0)
                            begin
                                tbl_we    = 1'b1;
                                tbl_waddr = '0;
                                tbl_wdata = '{group: in_data.group_number, seq: 3'd0};
                                fill_next = fptx_pkg::TBL_CNT_W'(1);
                                zseq_next = 3'd0;
                            end
                            else
                            begin
                                q_wr.push  = 1'b0;
                                pend_next  = entry;
                                grp_next   = in_data.group_number;
                                scan_next  = '0;
                                state_next = S_READ;
                            end
                        end
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (rd_reg.group == grp_reg)
                begin
                    tbl_we        = 1'b1;
                    tbl_waddr     = scan_reg;
                    tbl_wdata     = '{group: grp_reg, seq: rd_reg.seq + 3'd1};
                    pend_next.seq = rd_reg.seq + 3'd1;
                    state_next    = S_PUSH;
                end
                else if (scan_inc == fill_reg)
                begin
                    if (has_room)
                    begin
                        tbl_we    = 1'b1;
                        fill_next = fill_reg + fptx_pkg::TBL_CNT_W'(1);
                        zseq_next = 3'd0;
                    end
                    pend_next.seq = 3'd0;
                    state_next    = S_PUSH;
                end
                else
                begin
                    scan_next  = scan_inc[fptx_pkg::TBL_IDX_W-1:0];
                    state_next = S_READ;
                end
            end
            S_PUSH:
            begin
                if (!q_full)
                begin
                    q_wr.push  = 1'b1;
                    state_next = S_ACCEPT;
                end
            end
            default:
            begin
                state_next = S_ACCEPT;
            end
        endcase

        q_wr.entry = (state_reg == S_PUSH) ? pend_reg : entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_ACCEPT;
            pos_reg     <= 8'd0;
            dropped_reg <= 1'b0;
            fast_reg    <= 1'b0;
            noaddr_reg  <= 1'b0;
            fill_reg    <= '0;
            zseq_reg    <= 3'd0;
            scan_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            dropped_reg <= dropped_next;
            fast_reg    <= fast_next;
            noaddr_reg  <= noaddr_next;
            fill_reg    <= fill_next;
            zseq_reg    <= zseq_next;
            scan_reg    <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg  <= grp_next;
        pend_reg <= pend_next;
    end

    // sequence table, entries below the fill count hold nonzero groups
    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[tbl_waddr] <= tbl_wdata;
        rd_reg <= tbl_mem[scan_reg];
    end

endmodule

// ----- rtl/fptx_queue.sv -----
// fptx_queue: short fifo of frame bytes between front and back
// depends on fptx_pkg

module fptx_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  fptx_pkg::qpush_t q_wr,
    output logic             q_full,
    output fptx_pkg::qhead_t q_head,
    input  logic             q_pop
);

    fptx_pkg::qent_t                   slot_mem [fptx_pkg::QUEUE_DEPTH];
    logic [fptx_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [fptx_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [fptx_pkg::QUEUE_CNT_W-1:0]  count_reg, count_next;
    logic                              do_push;
    logic                              do_pop;

    always_comb
    begin
        q_full       = (count_reg == fptx_pkg::QUEUE_CNT_W'(fptx_pkg::QUEUE_DEPTH));
        q_head.valid = (count_reg != '0);
        q_head.entry = slot_mem[rd_ptr_reg];
        do_push      = q_wr.push && !q_full;
        do_pop       = q_pop && q_head.valid;
        wr_ptr_next  = do_push ? wr_ptr_reg + fptx_pkg::QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next  = do_pop ? rd_ptr_reg + fptx_pkg::QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next   = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + fptx_pkg::QUEUE_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - fptx_pkg::QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_mem[wr_ptr_reg] <= q_wr.entry;
    end

endmodule

// ----- rtl/fptx_back.sv -----
// fptx_back: packs queued bytes into 8-byte frames and holds the output word
// depends on fptx_pkg; fed by fptx_queue

module fptx_back (
    input  logic               clk,
    input  logic               rst_n,
    input  fptx_pkg::qhead_t   q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output fptx_pkg::out_word_t out_data
);

    logic [63:0]          asm_reg, asm_next;
    logic [2:0]           slot_reg, slot_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [2:0]           seq_reg, seq_next;
    logic [28:0]          ident_reg, ident_next;
    logic                 out_valid_reg, out_valid_next;
    fptx_pkg::out_word_t  out_reg, out_next;

    fptx_pkg::qent_t      e;
    logic [63:0]          base_asm;
    logic [2:0]           base_slot;
    logic [4:0]           base_cnt;
    logic [2:0]           base_seq;
    logic [28:0]          base_ident;
    logic [63:0]          new_asm;
    logic                 emit;

    always_comb
    begin
        e = q_head.entry;
        if (e.start)
        begin
            base_asm   = e.fast ? {48'hFFFF_FFFF_FFFF, e.length, e.seq, 5'd0} : '1;
            base_slot  = e.fast ? 3'd2 : 3'd0;
            base_cnt   = 5'd0;
            base_seq   = e.seq;
            base_ident = e.ident;
        end
        else
        begin
            base_asm   = asm_reg;
            base_slot  = slot_reg;
            base_cnt   = cnt_reg;
            base_seq   = seq_reg;
            base_ident = ident_reg;
        end
        new_asm = fptx_pkg::put_byte(base_asm, base_slot, e.data);
        emit    = (base_slot == 3'd7) || e.done;
        q_pop   = q_head.valid && (!emit || !out_valid_reg || out_ready);

        asm_next       = asm_reg;
        slot_next      = slot_reg;
        cnt_next       = cnt_reg;
        seq_next       = seq_reg;
        ident_next     = ident_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (q_pop)
        begin
            seq_next   = base_seq;
            ident_next = base_ident;
            if (emit)
            begin
                out_valid_next            = 1'b1;
                out_next.frame_identifier = base_ident;
                out_next.frame_data       = new_asm;
                out_next.frame_last       = e.done;
                cnt_next                  = base_cnt + 5'd1;
                asm_next                  = {56'hFF_FFFF_FFFF_FFFF, base_seq,
                                             base_cnt + 5'd1};
                slot_next                 = 3'd1;
            end
            else
            begin
                cnt_next  = base_cnt;
                asm_next  = new_asm;
                slot_next = base_slot + 3'd1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            slot_reg      <= 3'd0;
            cnt_reg       <= 5'd0;
            seq_reg       <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            slot_reg      <= slot_next;
            cnt_reg       <= cnt_next;
            seq_reg       <= seq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        asm_reg   <= asm_next;
        ident_reg <= ident_next;
        out_reg   <= out_next;
    end

endmodule

// ----- rtl/fast_packet_tx_framer_top.sv -----
// fast_packet_tx_framer_top: top level of the fast-packet transmit framer with its register port
// depends on fptx_pkg, fptx_front, fptx_queue, fptx_back
//
// input channel: in_valid/in_ready with in_data, one payload byte of a message per word;
//   message fields are taken on the first byte, byte_last marks the message end
// output channel: out_valid/out_ready with out_data, one 8-byte frame per word
// register port: claim_fail_address at byte address 0, written with a setup and
//   an access phase, read back on prdata, pready always high
// throughput: one byte per cycle while the queue has room; when the table is not empty, the
//   first byte of a fast-packet message with a nonzero group scans the sequence table,
//   reading and comparing filled entries in turn until a match, with in_ready low meanwhile
// path: a byte that completes a frame is written into the queue at its accepting edge unless
//   the table is scanned; fptx_back then pops it and registers the frame that drives out_valid
// reset: table empty, message position and flags cleared, claim_fail_address back to 254;
//   no clearing pass, the table is tracked by a fill count
// a stalled receiver holds the output frame; bytes keep packing until the next
//   frame is complete, then that byte and one more wait in the queue and in_ready
//   drops until the frame is taken

module fast_packet_tx_framer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  fptx_pkg::in_word_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output fptx_pkg::out_word_t                 out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fptx_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic             cfa_write;
    logic [7:0]       claim_fail_address_reg, claim_fail_address_next;
    logic             q_full;
    logic             q_pop;
    fptx_pkg::qpush_t q_wr;
    fptx_pkg::qhead_t q_head;

    assign pready    = 1'b1;
    assign cfa_write = psel && penable && pwrite && (paddr == fptx_pkg::ADDR_CFA);

    always_comb
    begin
        claim_fail_address_next = claim_fail_address_reg;
        if (cfa_write)
            claim_fail_address_next = pwdata[7:0];
        prdata = (paddr == fptx_pkg::ADDR_CFA) ? {24'd0, claim_fail_address_reg} : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            claim_fail_address_reg <= fptx_pkg::CFA_RESET;
        else
            claim_fail_address_reg <= claim_fail_address_next;
    end

    fptx_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .in_data            (in_data),
        .claim_fail_address (claim_fail_address_reg),
        .q_full             (q_full),
        .q_wr               (q_wr)
    );

    fptx_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .q_head (q_head),
        .q_pop  (q_pop)
    );

    fptx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
